// File: sv/fccs_pkg.sv
// Shared types, constants and a helper function of the flash capacitor charge supervisor.
package fccs_pkg;

	localparam int SAMPLE_BITS = 12;

	// Hysteresis bands and low-battery window, in reading counts / ticks
	localparam int CHARGE_BAND   = 100;
	localparam int GATE_BAND     = 20;
	localparam int FULL_BAND     = 100;
	localparam int LOWBATT_DELTA = 5;
	localparam int WINDOW_FIRST  = 10;
	localparam int WINDOW_LAST   = 20;
	localparam int TICK_CNT_BITS = 5;
	localparam int DUTY_BITS     = 3;
	localparam int DUTY_OFF_LAST = 3;
	localparam int DUTY_ON_TICK  = 4;

	// Fixed voltage-level limits
	localparam int VLIM_5 = 2800;
	localparam int VLIM_4 = 2900;
	localparam int VLIM_3 = 3000;
	localparam int VLIM_2 = 3100;
	localparam int VLIM_1 = 3200;

	localparam int IN_FIELD_BITS  = 2 * SAMPLE_BITS + 1;
	localparam int IN_TDATA_BITS  = 8 * ((IN_FIELD_BITS + 7) / 8);
	localparam int OUT_FIELD_BITS = 14;
	localparam int OUT_TDATA_BITS = 8 * ((OUT_FIELD_BITS + 7) / 8);

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = SAMPLE_BITS;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_CHARGE_STOP   = 3'd0,
		CFG_GATE_SWITCH   = 3'd1,
		CFG_CAP_FULL      = 3'd2,
		CFG_LAMP_WARM     = 3'd3,
		CFG_LAMP_HOT      = 3'd4,
		CFG_LAMP_OVERHEAT = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LVL_NORMAL   = 2'd0,
		LVL_WARM     = 2'd1,
		LVL_OVERHEAT = 2'd2
	} lamp_lvl_t;

	typedef struct packed {
		sample_t charge_stop;
		sample_t gate_switch;
		sample_t cap_full;
		sample_t lamp_warm;
		sample_t lamp_hot;
		sample_t lamp_overheat;
	} cfg_t;

	typedef struct packed {
		logic                     charger_run;
		logic                     gate_enable;
		logic                     full_flag;
		logic                     full_armed;
		logic [TICK_CNT_BITS-1:0] tick_cnt;
		sample_t                  first_sample;
		logic                     low_batt;
		logic                     permit;
		lamp_lvl_t                temp_level;
		logic                     blink;
		logic [DUTY_BITS-1:0]     duty;
		logic                     hot_armed;
		logic                     batt_armed;
	} state_t;

	typedef struct packed {
		logic       charger_on;
		logic       high_gate_on;
		logic       cap_full;
		logic       battery_low;
		logic       charge_allowed;
		lamp_lvl_t  lamp_level;
		logic       overheat_blink;
		logic       beep_full;
		logic       beep_hot;
		logic       beep_battery;
		logic [2:0] voltage_level;
	} result_t;

	function automatic logic [2:0] voltage_level_of(input sample_t v);
		int vi;
		vi = int'(v);
		if (vi < VLIM_5)      return 3'd5;
		else if (vi < VLIM_4) return 3'd4;
		else if (vi < VLIM_3) return 3'd3;
		else if (vi < VLIM_2) return 3'd2;
		else if (vi < VLIM_1) return 3'd1;
		else                  return 3'd0;
	endfunction

endpackage

// File: sv/fccs_step.sv
// Per-tick update: charger, full/low-battery, voltage level and lamp temperature steps.
module fccs_step (
	input  fccs_pkg::cfg_t    cfg,
	input  fccs_pkg::state_t  st,
	input  fccs_pkg::sample_t cap,
	input  fccs_pkg::sample_t lamp,
	input  logic              idle,
	output fccs_pkg::state_t  st_nxt,
	output fccs_pkg::result_t res
);
	import fccs_pkg::*;

	localparam int EXT_W = SAMPLE_BITS + 1;

	always_comb begin
		state_t                   s;
		logic [EXT_W-1:0]         cap_x;
		logic [TICK_CNT_BITS-1:0] cnt_inc;
		logic [DUTY_BITS-1:0]     duty_inc;
		sample_t                  diff;
		logic                     b_full;
		logic                     b_hot;
		logic                     b_batt;

		s        = st;
		cap_x    = {1'b0, cap};
		b_full   = 1'b0;
		b_hot    = 1'b0;
		b_batt   = 1'b0;
		cnt_inc  = st.tick_cnt + TICK_CNT_BITS'(1);
		duty_inc = st.duty + DUTY_BITS'(1);
		diff     = (cap > st.first_sample) ? cap - st.first_sample : st.first_sample - cap;

		// charger with hysteresis; gate only moves while charger is being (re)started
		if (idle && st.permit && !st.low_batt) begin
			if (cap > cfg.charge_stop) begin
				s.charger_run = 1'b0;
			end else if (cap_x + EXT_W'(CHARGE_BAND) < {1'b0, cfg.charge_stop}) begin
				if (cap < cfg.gate_switch)
					s.gate_enable = 1'b0;
				else if (cap_x > {1'b0, cfg.gate_switch} + EXT_W'(GATE_BAND))
					s.gate_enable = 1'b1;
				s.charger_run = 1'b1;
			end
		end else begin
			s.charger_run = 1'b0;
		end

		// capacitor full flag
		if (cap > cfg.cap_full) begin
			s.full_flag = 1'b1;
			if (st.full_armed) begin
				s.full_armed = 1'b0;
				b_full       = 1'b1;
			end
		end else if (cap_x + EXT_W'(FULL_BAND) < {1'b0, cfg.cap_full}) begin
			s.full_flag  = 1'b0;
			s.full_armed = 1'b1;
		end

		// low battery: stalled rise between window ticks
		if (cap < cfg.cap_full && st.permit && idle) begin
			s.tick_cnt = cnt_inc;
			if (cnt_inc == TICK_CNT_BITS'(WINDOW_FIRST)) begin
				s.first_sample = cap;
			end else if (cnt_inc == TICK_CNT_BITS'(WINDOW_LAST)) begin
				s.tick_cnt = '0;
				s.low_batt = (diff < SAMPLE_BITS'(LOWBATT_DELTA));
			end
		end

		// lamp temperature, tested from the top down
		if (lamp > cfg.lamp_overheat) begin
			s.temp_level = LVL_OVERHEAT;
			s.blink      = 1'b1;
			if (st.hot_armed) begin
				s.hot_armed = 1'b0;
				b_hot       = 1'b1;
			end
		end else if (lamp > cfg.lamp_hot) begin
			s.temp_level = LVL_WARM;
			s.blink      = 1'b0;
			s.hot_armed  = 1'b1;
		end else if (lamp > cfg.lamp_warm) begin
			s.temp_level = LVL_NORMAL;
			s.blink      = 1'b0;
			s.hot_armed  = 1'b1;
		end

		unique case (s.temp_level)
			LVL_NORMAL: begin
				s.permit = 1'b1;
			end
			LVL_WARM: begin
				// 3 ticks off, 1 tick on
				s.duty = duty_inc;
				if (duty_inc <= DUTY_BITS'(DUTY_OFF_LAST)) begin
					s.permit   = 1'b0;
					s.tick_cnt = '0;
				end else if (duty_inc == DUTY_BITS'(DUTY_ON_TICK)) begin
					s.permit = 1'b1;
					s.duty   = '0;
				end
			end
			default: begin
				s.permit = 1'b0;
			end
		endcase

		if (s.low_batt) begin
			if (st.batt_armed) begin
				s.batt_armed = 1'b0;
				b_batt       = 1'b1;
			end
			s.permit = 1'b0;
		end else begin
			s.batt_armed = 1'b1;
		end

		st_nxt             = s;
		res.charger_on     = s.charger_run;
		res.high_gate_on   = s.gate_enable;
		res.cap_full       = s.full_flag;
		res.battery_low    = s.low_batt;
		res.charge_allowed = s.permit;
		res.lamp_level     = s.temp_level;
		res.overheat_blink = s.blink;
		res.beep_full      = b_full;
		res.beep_hot       = b_hot;
		res.beep_battery   = b_batt;
		res.voltage_level  = voltage_level_of(cap);
	end

endmodule

// File: sv/flash_capacitor_charge_supervisor_core.sv
// Top level of the flash capacitor charge supervisor: registers, handshakes, config bank.
//
// channel   dir  handshake            content
// s_*       in   s_tvalid/s_tready    one tick: capacitor, lamp readings, motor idle
// m_*       out  m_tvalid/m_tready    one result per tick
// cfg_*     in   cfg_valid/cfg_ready  threshold register write (index, data)
//
// Flow: an accepted tick lands in the input register (_s1), its result is registered in
// the output register when the s1 item advances; one tick per clock is sustained while
// the output is not stalled. The step logic between the two registers is combinational.
// Reset (arst_n low, async): all supervisor state cleared, thresholds to defaults.
// Stalls: a held output stops the input register from draining; s_tready stays high
// while the input register is empty or moving on. cfg_ready is always high.
module flash_capacitor_charge_supervisor_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: cap_sample [11:0], lamp_sample [23:12], motor_idle [24], zero pad
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fccs_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	// tdata: charger_on, high_gate_on, cap_full, battery_low, charge_allowed,
	//        lamp_level[6:5], overheat_blink, beep_full, beep_hot, beep_battery,
	//        voltage_level[13:11], zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fccs_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fccs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fccs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import fccs_pkg::*;

	localparam sample_t RST_CHARGE_STOP   = SAMPLE_BITS'(3300);
	localparam sample_t RST_GATE_SWITCH   = SAMPLE_BITS'(1700);
	localparam sample_t RST_CAP_FULL      = SAMPLE_BITS'(2750);
	localparam sample_t RST_LAMP_WARM     = SAMPLE_BITS'(2000);
	localparam sample_t RST_LAMP_HOT      = SAMPLE_BITS'(2500);
	localparam sample_t RST_LAMP_OVERHEAT = SAMPLE_BITS'(3000);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_nxt;
	result_t res;
	result_t res_s2;

	logic    valid_s1;
	sample_t cap_s1;
	sample_t lamp_s1;
	logic    idle_s1;
	logic    advance;
	logic    s_xfer;

	// the s1 item moves on when the output register is free or being emptied
	assign advance   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// threshold bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charge_stop   <= RST_CHARGE_STOP;
			cfg_q.gate_switch   <= RST_GATE_SWITCH;
			cfg_q.cap_full      <= RST_CAP_FULL;
			cfg_q.lamp_warm     <= RST_LAMP_WARM;
			cfg_q.lamp_hot      <= RST_LAMP_HOT;
			cfg_q.lamp_overheat <= RST_LAMP_OVERHEAT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CHARGE_STOP:   cfg_q.charge_stop   <= cfg_data;
				CFG_GATE_SWITCH:   cfg_q.gate_switch   <= cfg_data;
				CFG_CAP_FULL:      cfg_q.cap_full      <= cfg_data;
				CFG_LAMP_WARM:     cfg_q.lamp_warm     <= cfg_data;
				CFG_LAMP_HOT:      cfg_q.lamp_hot      <= cfg_data;
				CFG_LAMP_OVERHEAT: cfg_q.lamp_overheat <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cap_s1  <= s_tdata[SAMPLE_BITS-1:0];
			lamp_s1 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			idle_s1 <= s_tdata[2*SAMPLE_BITS];
		end
	end

	fccs_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.cap    (cap_s1),
		.lamp   (lamp_s1),
		.idle   (idle_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

	// supervisor state commits only when the tick's result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {
		(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0),
		res_s2.voltage_level,
		res_s2.beep_battery,
		res_s2.beep_hot,
		res_s2.beep_full,
		res_s2.overheat_blink,
		res_s2.lamp_level,
		res_s2.charge_allowed,
		res_s2.battery_low,
		res_s2.cap_full,
		res_s2.high_gate_on,
		res_s2.charger_on
	};

	// a full beep only fires on the tick the capacitor becomes full
	a_beep_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.beep_full |-> res_s2.cap_full)
		else $error("beep_full without cap_full");

	// a battery beep comes with the low flag and a withdrawn permit
	a_beep_batt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.beep_battery |-> res_s2.battery_low && !res_s2.charge_allowed)
		else $error("beep_battery inconsistent with battery state");

	// a hot beep only while overheated and blinking
	a_beep_hot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.beep_hot |-> res_s2.lamp_level == LVL_OVERHEAT &&
		res_s2.overheat_blink)
		else $error("beep_hot outside overheat");

	// a pending tick in s1 is never dropped while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cap_s1) && $stable(st_q))
		else $error("input register lost a tick under stall");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the flash capacitor charge supervisor: directed ticks, random runs.
`timescale 1ns / 100ps

module testbench;
	import fccs_pkg::*;

	// Supervisor constants used by the shadow model and the stimulus
	localparam int CHARGE_BAND  = 100;
	localparam int GATE_BAND    = 20;
	localparam int FULL_BAND    = 100;
	localparam int STALL_DELTA  = 5;
	localparam int WIN_FIRST    = 10;
	localparam int WIN_LAST     = 20;
	localparam int SAMPLE_MAX   = 4095;
	localparam int RESULT_BITS  = 14;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_TICKS  = 180;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 40;

	// Result layout as it travels on m_tdata, highest field first
	typedef struct packed {
		logic [2:0] voltage_level;
		logic       beep_battery;
		logic       beep_hot;
		logic       beep_full;
		logic       overheat_blink;
		lamp_lvl_t  lamp_level;
		logic       charge_allowed;
		logic       battery_low;
		logic       cap_full;
		logic       high_gate_on;
		logic       charger_on;
	} tick_result_t;

	typedef struct packed {
		sample_t      cap;
		sample_t      lamp;
		logic         idle;
		logic         typed;
		tick_result_t want;
	} tick_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// tdata: cap_sample [11:0], lamp_sample [23:12], motor_idle [24], zero pad
	logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	// tdata: charger_on, high_gate_on, cap_full, battery_low, charge_allowed,
	//        lamp_level[6:5], overheat_blink, beep_full, beep_hot, beep_battery,
	//        voltage_level[13:11], zero pad
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	flash_capacitor_charge_supervisor_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Supervisor shadow: thresholds and state, advanced once per accepted tick
	// ------------------------------------------------------------------
	sample_t    lvl_reg [6];
	logic       sv_charging, sv_gate, sv_full, sv_full_armed;
	logic [4:0] sv_ticks;
	sample_t    sv_first;
	logic       sv_low_batt, sv_permit;
	lamp_lvl_t  sv_temp;
	logic       sv_blink;
	logic [2:0] sv_duty;
	logic       sv_hot_armed, sv_batt_armed;

	tick_result_t due_results [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int level_writes = 0;
	int full_beeps = 0, hot_beeps = 0, batt_beeps = 0;
	bit low_batt_seen = 0;
	int cycle_count = 0;

	function automatic tick_result_t advance_supervisor(sample_t cap, sample_t lamp, logic idle);
		tick_result_t r;
		int capi;
		int diff;
		r = '0;
		capi = int'(cap);

		// charger: stop above the level, restart only below the lower band edge
		if (idle && sv_permit && !sv_low_batt) begin
			if (cap > lvl_reg[CFG_CHARGE_STOP]) begin
				sv_charging = 1'b0;
			end else if (capi < int'(lvl_reg[CFG_CHARGE_STOP]) - CHARGE_BAND) begin
				if (cap < lvl_reg[CFG_GATE_SWITCH])
					sv_gate = 1'b0;
				else if (capi > int'(lvl_reg[CFG_GATE_SWITCH]) + GATE_BAND)
					sv_gate = 1'b1;
				sv_charging = 1'b1;
			end
		end else begin
			sv_charging = 1'b0;
		end

		// capacitor full with its own band; the beep re-arms on the way down
		if (cap > lvl_reg[CFG_CAP_FULL]) begin
			sv_full = 1'b1;
			if (sv_full_armed) begin
				sv_full_armed = 1'b0;
				r.beep_full = 1'b1;
			end
		end else if (capi < int'(lvl_reg[CFG_CAP_FULL]) - FULL_BAND) begin
			sv_full = 1'b0;
			sv_full_armed = 1'b1;
		end

		// stalled-rise window uses the permit from the previous tick
		if (cap < lvl_reg[CFG_CAP_FULL] && sv_permit && idle) begin
			sv_ticks = sv_ticks + 5'd1;
			if (sv_ticks == WIN_FIRST) begin
				sv_first = cap;
			end else if (sv_ticks == WIN_LAST) begin
				sv_ticks = '0;
				diff = (cap > sv_first) ? int'(cap) - int'(sv_first)
					: int'(sv_first) - int'(cap);
				sv_low_batt = (diff < STALL_DELTA);
			end
		end

		if (capi < 2800)      r.voltage_level = 3'd5;
		else if (capi < 2900) r.voltage_level = 3'd4;
		else if (capi < 3000) r.voltage_level = 3'd3;
		else if (capi < 3100) r.voltage_level = 3'd2;
		else if (capi < 3200) r.voltage_level = 3'd1;
		else                  r.voltage_level = 3'd0;

		// lamp: highest threshold first; at or below warm nothing changes
		if (lamp > lvl_reg[CFG_LAMP_OVERHEAT]) begin
			sv_temp = LVL_OVERHEAT;
			sv_blink = 1'b1;
			if (sv_hot_armed) begin
				sv_hot_armed = 1'b0;
				r.beep_hot = 1'b1;
			end
		end else if (lamp > lvl_reg[CFG_LAMP_HOT]) begin
			sv_temp = LVL_WARM;
			sv_blink = 1'b0;
			sv_hot_armed = 1'b1;
		end else if (lamp > lvl_reg[CFG_LAMP_WARM]) begin
			sv_temp = LVL_NORMAL;
			sv_blink = 1'b0;
			sv_hot_armed = 1'b1;
		end

		// warm level: three ticks off, one tick on
		if (sv_temp == LVL_NORMAL) begin
			sv_permit = 1'b1;
		end else if (sv_temp == LVL_WARM) begin
			sv_duty = sv_duty + 3'd1;
			if (sv_duty <= 3'd3) begin
				sv_permit = 1'b0;
				sv_ticks = '0;
			end else if (sv_duty <= 3'd4) begin
				sv_permit = 1'b1;
				sv_duty = '0;
			end
		end else begin
			sv_permit = 1'b0;
		end

		if (sv_low_batt) begin
			if (sv_batt_armed) begin
				sv_batt_armed = 1'b0;
				r.beep_battery = 1'b1;
			end
			sv_permit = 1'b0;
		end else begin
			sv_batt_armed = 1'b1;
		end

		r.charger_on     = sv_charging;
		r.high_gate_on   = sv_gate;
		r.cap_full       = sv_full;
		r.battery_low    = sv_low_batt;
		r.charge_allowed = sv_permit;
		r.lamp_level     = sv_temp;
		r.overheat_blink = sv_blink;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic sample_t clip_sample(int v);
		if (v < 0) return '0;
		if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
		return sample_t'(v);
	endfunction

	// One tick transfer; the expectation is formed at the accepting edge.
	// typed rows carry a hand-written result in place of the shadow's.
	task automatic send_tick(sample_t cap, sample_t lamp, logic idle, logic typed,
			tick_result_t want);
		tick_result_t r;
		s_tdata <= {7'd0, idle, lamp, cap};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = advance_supervisor(cap, lamp, idle);
		due_results.push_back(typed ? want : r);
		ticks_sent++;
		// sender gaps: one draw per cycle, so gap_pct is the idle share
		if ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
	endtask

	// Hold off the sender until every result is back, plus pipeline slack
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_level(cfg_idx_t idx, sample_t val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		lvl_reg[idx] = val;
		level_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_levels(int stop, int gate, int full, int warm, int hot, int over);
		write_level(CFG_CHARGE_STOP, clip_sample(stop));
		write_level(CFG_GATE_SWITCH, clip_sample(gate));
		write_level(CFG_CAP_FULL, clip_sample(full));
		write_level(CFG_LAMP_WARM, clip_sample(warm));
		write_level(CFG_LAMP_HOT, clip_sample(hot));
		write_level(CFG_LAMP_OVERHEAT, clip_sample(over));
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 51; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 51; end
			default: begin gap_pct = 9; stall_pct = 9; end
		endcase
	endtask

	// Random ticks in segments: charging ramps, readings parked around a
	// threshold, and plain noise. Unless allow_stall is set, a window end that
	// would see a stalled rise is nudged off, since low battery never clears.
	task automatic run_random(int count, bit allow_stall);
		int done;
		int kind, len, k;
		int c, l, centre_c, centre_l;
		logic idle;
		sample_t cap;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(8, 40);
			c = $urandom_range(0, 1500);
			l = $urandom_range(1800, 3300);
			case ($urandom_range(0, 7))
				0: centre_c = lvl_reg[CFG_CHARGE_STOP];
				1: centre_c = int'(lvl_reg[CFG_CHARGE_STOP]) - CHARGE_BAND;
				2: centre_c = lvl_reg[CFG_GATE_SWITCH];
				3: centre_c = int'(lvl_reg[CFG_GATE_SWITCH]) + GATE_BAND;
				4: centre_c = lvl_reg[CFG_CAP_FULL];
				5: centre_c = int'(lvl_reg[CFG_CAP_FULL]) - FULL_BAND;
				6: centre_c = 2800 + 100 * $urandom_range(0, 4);
				default: centre_c = $urandom_range(0, SAMPLE_MAX);
			endcase
			case ($urandom_range(0, 2))
				0: centre_l = lvl_reg[CFG_LAMP_WARM];
				1: centre_l = lvl_reg[CFG_LAMP_HOT];
				default: centre_l = lvl_reg[CFG_LAMP_OVERHEAT];
			endcase
			for (k = 0; k < len && done < count; k++) begin
				if (kind <= 5) begin
					// capacitor charging up, dumped when the flash fires
					c = c + $urandom_range(0, 90);
					if (c > SAMPLE_MAX || $urandom_range(0, 49) == 0)
						c = $urandom_range(0, 800);
					l = int'(clip_sample(l + $urandom_range(0, 80) - 40));
					idle = ($urandom_range(0, 9) != 0);
				end else if (kind <= 7) begin
					c = centre_c + $urandom_range(0, 60) - 30;
					l = centre_l + $urandom_range(0, 40) - 20;
					idle = ($urandom_range(0, 15) != 0);
				end else begin
					c = $urandom_range(0, SAMPLE_MAX);
					l = $urandom_range(0, SAMPLE_MAX);
					idle = $urandom_range(0, 1);
				end
				cap = clip_sample(c);
				if (!allow_stall && sv_ticks == WIN_LAST - 1 && sv_permit && idle
						&& cap < lvl_reg[CFG_CAP_FULL]) begin
					if ((cap > sv_first ? cap - sv_first : sv_first - cap) < STALL_DELTA)
						cap = (sv_first >= 8) ? sv_first - 12'd8 : sv_first + 12'd8;
				end
				send_tick(cap, clip_sample(l), idle, 1'b0, '0);
				done++;
				if ($urandom_range(0, 199) == 0)
					drain_results();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Directed ticks. Rows 0..2 carry results worked out by hand.
	// ------------------------------------------------------------------
	localparam int DIRECTED_ROWS = 26;
	tick_row_t directed_ticks [DIRECTED_ROWS] = '{
		// after reset, motor busy: nothing runs, permit comes up from the lamp step
		'{12'd0, 12'd0, 1'b0, 1'b1,
			'{voltage_level: 3'd5, lamp_level: LVL_NORMAL, charge_allowed: 1'b1, default: 1'b0}},
		// both readings at full scale: full beep, overheat without a beep (not armed)
		'{12'd4095, 12'd4095, 1'b1, 1'b1,
			'{voltage_level: 3'd0, lamp_level: LVL_OVERHEAT, overheat_blink: 1'b1,
			  beep_full: 1'b1, cap_full: 1'b1, default: 1'b0}},
		// readings at zero: lamp level held, full flag drops
		'{12'd0, 12'd0, 1'b1, 1'b1,
			'{voltage_level: 3'd5, lamp_level: LVL_OVERHEAT, overheat_blink: 1'b1,
			  default: 1'b0}},
		'{12'd1000, 12'd2200, 1'b1, 1'b0, '0},   // lamp back to normal, re-arm
		'{12'd1000, 12'd2200, 1'b1, 1'b0, '0},   // charger starts, gate off
		'{12'd1800, 12'd2200, 1'b1, 1'b0, '0},   // above gate band: gate on
		'{12'd1710, 12'd2200, 1'b1, 1'b0, '0},   // inside gate band: held
		'{12'd2800, 12'd2200, 1'b1, 1'b0, '0},   // full, beep
		'{12'd3250, 12'd2200, 1'b1, 1'b0, '0},   // inside charge band: held
		'{12'd3301, 12'd2200, 1'b1, 1'b0, '0},   // above stop level
		'{12'd3000, 12'd2200, 1'b0, 1'b0, '0},   // zoom motor moving
		'{12'd2000, 12'd2600, 1'b1, 1'b0, '0},   // warm level: duty cycle
		'{12'd2000, 12'd2600, 1'b1, 1'b0, '0},
		'{12'd2000, 12'd2600, 1'b1, 1'b0, '0},
		'{12'd2000, 12'd2600, 1'b1, 1'b0, '0},
		'{12'd2000, 12'd2600, 1'b1, 1'b0, '0},
		'{12'd2000, 12'd3001, 1'b1, 1'b0, '0},   // overheat, beep
		'{12'd2000, 12'd4095, 1'b1, 1'b0, '0},   // no second beep
		'{12'd2000, 12'd2001, 1'b1, 1'b0, '0},   // just above warm: re-arm
		'{12'd2799, 12'd3500, 1'b1, 1'b0, '0},   // beep again
		'{12'd2899, 12'd1000, 1'b1, 1'b0, '0},   // lamp low: level held
		'{12'd2999, 12'd2100, 1'b1, 1'b0, '0},
		'{12'd3099, 12'd2100, 1'b1, 1'b0, '0},
		'{12'd3199, 12'd2100, 1'b1, 1'b0, '0},
		'{12'd3200, 12'd2100, 1'b1, 1'b0, '0},
		'{12'd4095, 12'd0, 1'b0, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < PRINT_LIMIT)
			$display("MISMATCH at result %0d: %s got %0d want %0d",
				results_checked, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_monitor
		tick_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = tick_result_t'(m_tdata[RESULT_BITS-1:0]);
			if (due_results.size() == 0) begin
				report_mismatch("result with no tick pending", 1, 0);
			end else begin
				want = due_results.pop_front();
				if (got.charger_on != want.charger_on)
					report_mismatch("charger_on", got.charger_on, want.charger_on);
				if (got.high_gate_on != want.high_gate_on)
					report_mismatch("high_gate_on", got.high_gate_on, want.high_gate_on);
				if (got.cap_full != want.cap_full)
					report_mismatch("cap_full", got.cap_full, want.cap_full);
				if (got.battery_low != want.battery_low)
					report_mismatch("battery_low", got.battery_low, want.battery_low);
				if (got.charge_allowed != want.charge_allowed)
					report_mismatch("charge_allowed", got.charge_allowed, want.charge_allowed);
				if (got.lamp_level != want.lamp_level)
					report_mismatch("lamp_level", got.lamp_level, want.lamp_level);
				if (got.overheat_blink != want.overheat_blink)
					report_mismatch("overheat_blink", got.overheat_blink, want.overheat_blink);
				if (got.beep_full != want.beep_full)
					report_mismatch("beep_full", got.beep_full, want.beep_full);
				if (got.beep_hot != want.beep_hot)
					report_mismatch("beep_hot", got.beep_hot, want.beep_hot);
				if (got.beep_battery != want.beep_battery)
					report_mismatch("beep_battery", got.beep_battery, want.beep_battery);
				if (got.voltage_level != want.voltage_level)
					report_mismatch("voltage_level", got.voltage_level, want.voltage_level);
				full_beeps += want.beep_full;
				hot_beeps += want.beep_hot;
				batt_beeps += want.beep_battery;
				if (want.battery_low)
					low_batt_seen = 1;
			end
			results_checked++;
		end
	end

	// Receiver stalls: fresh draw every cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct);

	// Hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding",
				cycle_count, due_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		int p, i;
		lvl_reg[CFG_CHARGE_STOP]   = 12'd3300;
		lvl_reg[CFG_GATE_SWITCH]   = 12'd1700;
		lvl_reg[CFG_CAP_FULL]      = 12'd2750;
		lvl_reg[CFG_LAMP_WARM]     = 12'd2000;
		lvl_reg[CFG_LAMP_HOT]      = 12'd2500;
		lvl_reg[CFG_LAMP_OVERHEAT] = 12'd3000;
		sv_charging = 0; sv_gate = 0; sv_full = 0; sv_full_armed = 0;
		sv_ticks = '0; sv_first = '0; sv_low_batt = 0; sv_permit = 0;
		sv_temp = LVL_NORMAL; sv_blink = 0; sv_duty = '0;
		sv_hot_armed = 0; sv_batt_armed = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed ticks on reset thresholds, no idling
		set_idling(0);
		for (i = 0; i < DIRECTED_ROWS; i++)
			send_tick(directed_ticks[i].cap, directed_ticks[i].lamp, directed_ticks[i].idle,
				directed_ticks[i].typed, directed_ticks[i].want);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			case (p)
				0: ;   // keep reset thresholds
				1: load_levels(100, 0, 100, 0, 0, 0);
				2: load_levels(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
					SAMPLE_MAX);
				4: load_levels(3300, 1700, 2750, 2000, 2500, 3000);
				6: begin
					// lamp thresholds in reverse order
					load_levels($urandom_range(2600, 3700), $urandom_range(1000, 2500),
						$urandom_range(2000, 3300), $urandom_range(2600, 3400),
						$urandom_range(2000, 2600), $urandom_range(1200, 2000));
				end
				default: begin
					i = $urandom_range(1500, 2300);
					load_levels(
						$urandom_range(0, 1) ? $urandom_range(2600, 3700)
							: $urandom_range(100, SAMPLE_MAX),
						$urandom_range(0, 1) ? $urandom_range(1000, 2500)
							: $urandom_range(0, SAMPLE_MAX),
						$urandom_range(0, 1) ? $urandom_range(2000, 3300)
							: $urandom_range(100, SAMPLE_MAX),
						i, i + $urandom_range(0, 800), i + 800 + $urandom_range(0, 800));
				end
			endcase
			set_idling(p % 4);
			run_random(PHASE_TICKS, 0);
		end

		// low battery last: once set it only clears with a reset
		drain_results();
		load_levels(3300, 1700, 2750, 2000, 2500, 3000);
		set_idling(3);
		for (i = 0; i < 50; i++)
			send_tick(12'd1200, 12'd2200, 1'b1, 1'b0, '0);
		run_random(40, 1);

		drain_results();
		repeat (8) @(posedge clk);

		$display("Ran %0d ticks through %0d threshold settings (%0d register writes),",
			ticks_sent, RANDOM_PHASES + 2, level_writes);
		$display("%0d results checked; pulses: full %0d, hot %0d, battery %0d; low battery: %0d",
			results_checked, full_beeps, hot_beeps, batt_beeps, low_batt_seen);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
sv/fccs_pkg.sv
sv/fccs_step.sv
sv/flash_capacitor_charge_supervisor_core.sv
bench/testbench.sv
